// ===== src/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// drs_pkg - shared definitions for the drift-steered cubic resampler
// Fixed-point formats, field widths, register map and lane control word.
// ----------------------------------------------------------------------------
package drs_pkg;

  // Phase is unsigned Q2.F and step is unsigned Q1.F, one is 2^F
  localparam int PHASE_FRAC_BITS = 24;
  localparam int FIFO_CAPACITY   = 32768;            // power of two, at most 2^F
  localparam int CAP_LOG2        = $clog2(FIFO_CAPACITY);

  localparam int STEP_W  = PHASE_FRAC_BITS + 1;
  localparam int PHASE_W = PHASE_FRAC_BITS + 2;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int FILL_W   = 16;
  localparam int T_W      = 16;                      // interpolation fraction
  localparam int COEF_W   = 20;
  localparam int ACC_W    = 38;
  localparam int Y_SHIFT  = 17;                      // Horner result is 2^17 times the sample

  localparam int LANES   = 2;                        // lane 0 left, lane 1 right
  localparam int MAX_RUN = 2;
  localparam int RUN_W   = $clog2(MAX_RUN + 1);

  localparam logic [PHASE_W-1:0] ONE_PHASE = PHASE_W'(1) << PHASE_FRAC_BITS;
  localparam logic [STEP_W-1:0]  ONE_STEP  = STEP_W'(1) << PHASE_FRAC_BITS;

  // Register map, index is paddr[3:2]
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;
  localparam logic [1:0] REG_DRIFT_GAIN = 2'd0;
  localparam logic [1:0] REG_STEP_LOWER = 2'd1;
  localparam logic [1:0] REG_STEP_UPPER = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET  = GAIN_W'(1311);
  localparam logic [STEP_W-1:0] LOWER_RESET = STEP_W'(16609444);
  localparam logic [STEP_W-1:0] UPPER_RESET = STEP_W'(16944988);

  // Horner coefficient select, highest order first
  localparam logic [1:0] COEF_SEL_C2 = 2'd0;
  localparam logic [1:0] COEF_SEL_C1 = 2'd1;
  localparam logic [1:0] COEF_SEL_C0 = 2'd2;

  typedef struct packed {
    logic       load;   // latch coefficients, seed accumulator with C3
    logic       iter;   // one Horner step
    logic [1:0] sel;    // coefficient added in this step
  } lane_ctrl_t;

endpackage

// ===== src/drs_step.sv =====
// ----------------------------------------------------------------------------
// drs_step - rate step update
// Scales the fill error by the drift gain (one registered multiply), then
// clamps 1 +/- d to the configured bounds.
// ----------------------------------------------------------------------------
module drs_step (
  input  logic                        clk,
  input  logic                        load,
  input  logic [drs_pkg::FILL_W-1:0]  fill_level,
  input  logic [drs_pkg::GAIN_W-1:0]  drift_gain,
  input  logic [drs_pkg::STEP_W-1:0]  step_lower,
  input  logic [drs_pkg::STEP_W-1:0]  step_upper,
  output logic [drs_pkg::STEP_W-1:0]  step_new
);
  import drs_pkg::*;

  localparam int E_W    = FILL_W + 2;
  localparam int M_W    = FILL_W + 1;
  localparam int R_SH   = PHASE_FRAC_BITS - CAP_LOG2;
  localparam int R_W    = M_W + R_SH;
  localparam int PROD_W = R_W + GAIN_W;
  localparam int D_W    = PROD_W - Y_SHIFT;
  localparam int S_W    = D_W + 2;

  logic signed [E_W-1:0]    err;
  logic                     err_neg;
  logic [M_W-1:0]           err_mag;
  logic [R_W-1:0]           ratio;
  logic [PROD_W-1:0]        prod;
  logic [D_W-1:0]           d_r;
  logic                     neg_r;
  logic signed [S_W-1:0]    step_raw;

  always_comb begin
    err     = $signed({1'b0, fill_level, 1'b0}) - $signed(E_W'(FIFO_CAPACITY));
    err_neg = err[E_W-1];
    err_mag = err_neg ? M_W'(-err) : M_W'(err);
    // division by a power-of-two capacity is exact as a shift
    ratio   = R_W'(err_mag) << R_SH;
    prod    = PROD_W'(ratio) * PROD_W'(drift_gain);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r   <= D_W'(prod >> Y_SHIFT);
      neg_r <= err_neg;
    end
  end

  always_comb begin
    if (neg_r) begin
      step_raw = $signed(S_W'(ONE_STEP)) - $signed(S_W'(d_r));
    end else begin
      step_raw = $signed(S_W'(ONE_STEP)) + $signed(S_W'(d_r));
    end
    // a negative step wraps huge, so it lands on the upper bound
    priority if (!step_raw[S_W-1] && (step_raw < $signed(S_W'(step_lower)))) begin
      step_new = step_lower;
    end else if (step_raw[S_W-1] || (step_raw > $signed(S_W'(step_upper)))) begin
      step_new = step_upper;
    end else begin
      step_new = STEP_W'(step_raw);
    end
  end

endmodule

// ===== src/drs_lane.sv =====
// ----------------------------------------------------------------------------
// drs_lane - one channel of Catmull-Rom interpolation
// Forms the cubic coefficients from four samples and runs Horner in three
// steps on a single multiply-add.
// ----------------------------------------------------------------------------
module drs_lane (
  input  logic                               clk,
  input  drs_pkg::lane_ctrl_t                ctrl,
  input  logic signed [drs_pkg::SAMPLE_W-1:0] s_m1,
  input  logic signed [drs_pkg::SAMPLE_W-1:0] s_0,
  input  logic signed [drs_pkg::SAMPLE_W-1:0] s_1,
  input  logic signed [drs_pkg::SAMPLE_W-1:0] s_2,
  input  logic [drs_pkg::T_W-1:0]            t_frac,
  output logic signed [drs_pkg::ACC_W-1:0]   acc
);
  import drs_pkg::*;

  localparam int P_W = ACC_W + T_W + 1;

  logic signed [COEF_W-1:0] xm, x0, x1, x2;
  logic signed [COEF_W-1:0] c0, c1, c2, c3;
  logic signed [COEF_W-1:0] c0_r, c1_r, c2_r;
  logic signed [COEF_W-1:0] coef;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [P_W-1:0]    prod;
  logic signed [P_W-1:0]    prod_sh;

  always_comb begin
    xm = COEF_W'(s_m1);
    x0 = COEF_W'(s_0);
    x1 = COEF_W'(s_1);
    x2 = COEF_W'(s_2);
    // twice the textbook coefficients
    c0 = x0 <<< 1;
    c1 = x1 - xm;
    c2 = (xm <<< 1) - (x0 <<< 2) - x0 + (x1 <<< 2) - x2;
    c3 = x2 - xm + (x0 - x1) + ((x0 - x1) <<< 1);
  end

  always_comb begin
    unique case (ctrl.sel)
      COEF_SEL_C2: coef = c2_r;
      COEF_SEL_C1: coef = c1_r;
      default:     coef = c0_r;
    endcase
    prod    = acc_r * $signed({1'b0, t_frac});
    prod_sh = prod >>> T_W;   // floor
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      c0_r  <= c0;
      c1_r  <= c1;
      c2_r  <= c2;
      // seeding with C3 * 2^16 makes the first step C3*t + C2*2^16 exactly
      acc_r <= ACC_W'(c3) <<< T_W;
    end else if (ctrl.iter) begin
      acc_r <= ACC_W'(prod_sh) + (ACC_W'(coef) <<< T_W);
    end
  end

  assign acc = acc_r;

endmodule

// ===== src/drs_merge.sv =====
// ----------------------------------------------------------------------------
// drs_merge - output stage
// Scales and saturates both lane results and holds the stereo word in the
// output register until it is taken.
// ----------------------------------------------------------------------------
module drs_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic                                last,
  input  logic signed [drs_pkg::ACC_W-1:0]    acc_left,
  input  logic signed [drs_pkg::ACC_W-1:0]    acc_right,
  output logic                                free,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [drs_pkg::SAMPLE_W-1:0] out_left_out,
  output logic signed [drs_pkg::SAMPLE_W-1:0] out_right_out,
  output logic                                out_last_of_run
);
  import drs_pkg::*;

  localparam int Q_W = ACC_W - Y_SHIFT + 1;

  function automatic logic signed [SAMPLE_W-1:0] scale_sat(
    input logic signed [ACC_W-1:0] a
  );
    logic [ACC_W-1:0]      mag;
    logic signed [Q_W-1:0] q;
    logic signed [SAMPLE_W-1:0] y;
    mag = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    // truncate toward zero
    q = $signed(Q_W'(mag >> Y_SHIFT));
    if (a[ACC_W-1]) begin
      q = -q;
    end
    priority if (q > $signed(Q_W'(32767))) begin
      y = 16'sh7fff;
    end else if (q < -$signed(Q_W'(32768))) begin
      y = -16'sh8000;
    end else begin
      y = SAMPLE_W'(q);
    end
    return y;
  endfunction

  logic                       valid_r;
  logic signed [SAMPLE_W-1:0] left_r, right_r;
  logic                       last_r;

  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= scale_sat(acc_left);
      right_r <= scale_sat(acc_right);
      last_r  <= last;
    end
  end

  assign out_valid       = valid_r;
  assign out_left_out    = left_r;
  assign out_right_out   = right_r;
  assign out_last_of_run = last_r;

endmodule

// ===== src/drift_steered_cubic_resampler.sv =====
// ----------------------------------------------------------------------------
// drift_steered_cubic_resampler - stereo Catmull-Rom fractional resampler
// Fill-level steered rate step, two interpolation lanes, APB register port.
// ----------------------------------------------------------------------------
// Each input word is one stereo frame and yields zero, one or two output
// words; last_of_run marks the final one. An input word occupies the block
// through an optional rate update (the gain multiply, when update_rate asks
// for a new step), then for each output word a phase test, three Horner
// steps on the per-lane multiply-add and a handover to the output register,
// and a closing phase test. Left and right are interpolated side by side,
// so the rate does not depend on the channel count. The output register
// lets the next input word in while a result is still waiting downstream; a
// stall there holds the block only when the next result is ready. Registers:
// 0x0 drift_gain (Q0.16), 0x4 step_lower_bound and 0x8 step_upper_bound
// (Q1.24); write them only while the block is idle.
module drift_steered_cubic_resampler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [drs_pkg::SAMPLE_W-1:0] in_left_sample,
  input  logic signed [drs_pkg::SAMPLE_W-1:0] in_right_sample,
  input  logic                                in_update_rate,
  input  logic [drs_pkg::FILL_W-1:0]          in_fill_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [drs_pkg::SAMPLE_W-1:0] out_left_out,
  output logic signed [drs_pkg::SAMPLE_W-1:0] out_right_out,
  output logic                                out_last_of_run,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [drs_pkg::CFG_AW-1:0]          paddr,
  input  logic [drs_pkg::CFG_DW-1:0]          pwdata,
  output logic [drs_pkg::CFG_DW-1:0]          prdata,
  output logic                                pready
);
  import drs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_CHECK,
    ST_RUN,
    ST_EMIT
  } state_t;

  state_t state_r;

  logic [GAIN_W-1:0]  gain_r;
  logic [STEP_W-1:0]  lower_r, upper_r;
  logic [STEP_W-1:0]  rate_step_r;
  logic [PHASE_W-1:0] phase_r;
  logic [RUN_W-1:0]   run_cnt_r;
  logic [1:0]         iter_r;

  logic signed [SAMPLE_W-1:0] hist_r [LANES][3];
  logic signed [SAMPLE_W-1:0] new_r  [LANES];
  logic signed [ACC_W-1:0]    lane_acc [LANES];

  logic               accept;
  logic               step_load;
  logic [STEP_W-1:0]  step_new;
  logic [PHASE_W-1:0] phase_sum;
  logic               run_ok;
  logic               merge_free;
  logic               merge_load;
  logic               merge_last;
  logic               cfg_wr;
  lane_ctrl_t         lane_ctrl;
  logic [T_W-1:0]     t_frac;

  // --- configuration port ---------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RESET;
      lower_r <= LOWER_RESET;
      upper_r <= UPPER_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DRIFT_GAIN: gain_r  <= pwdata[GAIN_W-1:0];
        REG_STEP_LOWER: lower_r <= pwdata[STEP_W-1:0];
        REG_STEP_UPPER: upper_r <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DRIFT_GAIN: prdata = CFG_DW'(gain_r);
      REG_STEP_LOWER: prdata = CFG_DW'(lower_r);
      REG_STEP_UPPER: prdata = CFG_DW'(upper_r);
      default:        prdata = '0;
    endcase
  end

  // --- control --------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign step_load = accept && in_update_rate;
  assign phase_sum = phase_r + PHASE_W'(rate_step_r);
  assign run_ok    = (phase_r < ONE_PHASE) && (run_cnt_r < RUN_W'(MAX_RUN));
  assign t_frac    = phase_r[PHASE_FRAC_BITS-1 -: T_W];

  assign merge_load = (state_r == ST_EMIT) && merge_free;
  assign merge_last = (run_cnt_r == RUN_W'(MAX_RUN - 1)) || (phase_sum >= ONE_PHASE);

  always_comb begin
    lane_ctrl.load = (state_r == ST_CHECK) && run_ok;
    lane_ctrl.iter = (state_r == ST_RUN);
    lane_ctrl.sel  = iter_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rate_step_r <= ONE_STEP;
      phase_r     <= '0;
      run_cnt_r   <= '0;
      iter_r      <= COEF_SEL_C2;
      for (int l = 0; l < LANES; l++) begin
        for (int k = 0; k < 3; k++) begin
          hist_r[l][k] <= '0;
        end
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            new_r[0]  <= in_left_sample;
            new_r[1]  <= in_right_sample;
            run_cnt_r <= '0;
            state_r   <= in_update_rate ? ST_CLAMP : ST_CHECK;
          end
        end
        ST_CLAMP: begin
          rate_step_r <= step_new;
          state_r     <= ST_CHECK;
        end
        ST_CHECK: begin
          if (run_ok) begin
            iter_r  <= COEF_SEL_C2;
            state_r <= ST_RUN;
          end else begin
            // run done: phase minus one, or resync to zero if the cap hit below one
            phase_r <= (phase_r < ONE_PHASE) ? '0 : phase_r - ONE_PHASE;
            for (int l = 0; l < LANES; l++) begin
              hist_r[l][0] <= hist_r[l][1];
              hist_r[l][1] <= hist_r[l][2];
              hist_r[l][2] <= new_r[l];
            end
            state_r <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if (iter_r == COEF_SEL_C0) begin
            state_r <= ST_EMIT;
          end else begin
            iter_r <= iter_r + 2'd1;
          end
        end
        ST_EMIT: begin
          if (merge_free) begin
            phase_r   <= phase_sum;
            run_cnt_r <= run_cnt_r + RUN_W'(1);
            state_r   <= ST_CHECK;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // --- datapath -------------------------------------------------------------
  drs_step u_step (
    .clk        (clk),
    .load       (step_load),
    .fill_level (in_fill_level),
    .drift_gain (gain_r),
    .step_lower (lower_r),
    .step_upper (upper_r),
    .step_new   (step_new)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    drs_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .s_m1   (hist_r[g][0]),
      .s_0    (hist_r[g][1]),
      .s_1    (hist_r[g][2]),
      .s_2    (new_r[g]),
      .t_frac (t_frac),
      .acc    (lane_acc[g])
    );
  end

  drs_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (merge_load),
    .last            (merge_last),
    .acc_left        (lane_acc[0]),
    .acc_right       (lane_acc[1]),
    .free            (merge_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - drift_steered_cubic_resampler
// Drives stereo frames through the valid/stall input, writes the drift gain
// and step bounds over the APB port between phases, and checks each output
// word against a bit-exact Catmull-Rom resampler model held locally, or
// against its table values for a typed directed row. A short directed table
// comes first, followed by constrained-by-hand random frames under several
// register settings, random idling on both sides and one long downstream hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import drs_pkg::*;

  localparam int ITEMS_PER_PHASE = 265;
  localparam int N_PHASES        = 7;
  localparam int DRAIN_CYCLES    = 40;       // longer than any stretch for which a frame holds an open block
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 1500000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       upd;
    logic [FILL_W-1:0]          fill;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
  } out_word_t;

  typedef enum logic [0:0] {ROW_FRAME, ROW_REGS} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    frame_t                     fr;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] exp_left;
    logic signed [SAMPLE_W-1:0] exp_right;
    logic [GAIN_W-1:0]          gain;
    logic [STEP_W-1:0]          lower;
    logic [STEP_W-1:0]          upper;
  } row_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_left_sample;
  logic signed [SAMPLE_W-1:0] in_right_sample;
  logic                       in_update_rate;
  logic [FILL_W-1:0]          in_fill_level;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_left_out;
  logic signed [SAMPLE_W-1:0] out_right_out;
  logic                       out_last_of_run;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [CFG_AW-1:0]          paddr;
  logic [CFG_DW-1:0]          pwdata;
  logic [CFG_DW-1:0]          prdata;
  logic                       pready;

  drift_steered_cubic_resampler dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_update_rate  (in_update_rate),
    .in_fill_level   (in_fill_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .out_last_of_run (out_last_of_run),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Resampler model state and register mirror
  logic signed [SAMPLE_W-1:0] hist_l [3];   // oldest first
  logic signed [SAMPLE_W-1:0] hist_r [3];
  logic [PHASE_W-1:0]         phase_q;
  logic [STEP_W-1:0]          step_q;
  logic [GAIN_W-1:0]          gain_q;
  logic [STEP_W-1:0]          lower_q;
  logic [STEP_W-1:0]          upper_q;

  out_word_t predicted_words [$];
  row_t      plan [$];
  int        mismatches = 0;
  int        cycle_count;
  logic      hold_off_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_model();
    for (int i = 0; i < 3; i++) begin
      hist_l[i] = '0;
      hist_r[i] = '0;
    end
    phase_q = '0;
    step_q  = ONE_STEP;
    gain_q  = GAIN_RESET;
    lower_q = LOWER_RESET;
    upper_q = UPPER_RESET;
  endfunction

  // Horner in Q16 on twice the textbook coefficients, result / 2^17 toward zero
  function automatic logic signed [SAMPLE_W-1:0] catmull(input longint sm, input longint s0,
                                                         input longint s1, input longint s2,
                                                         input longint t);
    longint c0, c1, c2, c3, a, y;
    c0 = 2 * s0;
    c1 = s1 - sm;
    c2 = 2 * sm - 5 * s0 + 4 * s1 - s2;
    c3 = s2 - sm + 3 * (s0 - s1);
    a  = c3 * t + c2 * 65536;
    a  = ((a * t) >>> 16) + c1 * 65536;
    a  = ((a * t) >>> 16) + c0 * 65536;
    y  = (a >= 0) ? (a >>> 17) : -((-a) >>> 17);
    if (y > 32767)
      y = 32767;
    else if (y < -32768)
      y = -32768;
    return y[SAMPLE_W-1:0];
  endfunction

  function automatic void retune_step(input logic [FILL_W-1:0] fill);
    longint          e;
    longint unsigned m, r, d, s, one;
    one = 64'd1 << PHASE_FRAC_BITS;
    e   = 2 * longint'(fill) - FIFO_CAPACITY;
    m   = (e < 0) ? -e : e;
    r   = (m << PHASE_FRAC_BITS) / FIFO_CAPACITY;
    d   = (r * gain_q) >> 17;
    s   = (e >= 0) ? one + d : one - d;
    // lower is tested first, so crossed bounds resolve to lower when below it
    if (s < lower_q)
      s = lower_q;
    else if (s > upper_q)
      s = upper_q;
    step_q = s[STEP_W-1:0];
  endfunction

  function automatic void resample_frame(input frame_t f, output out_word_t res [MAX_RUN],
                                         output int n);
    n = 0;
    for (int i = 0; i < MAX_RUN; i++)
      res[i] = '0;
    if (f.upd)
      retune_step(f.fill);
    while (phase_q < ONE_PHASE && n < MAX_RUN) begin
      res[n].left  = catmull(hist_l[0], hist_l[1], hist_l[2], f.left,
                             longint'(phase_q >> (PHASE_FRAC_BITS - T_W)));
      res[n].right = catmull(hist_r[0], hist_r[1], hist_r[2], f.right,
                             longint'(phase_q >> (PHASE_FRAC_BITS - T_W)));
      res[n].last  = 1'b0;
      phase_q = phase_q + PHASE_W'(step_q);
      n++;
    end
    if (n > 0)
      res[n-1].last = 1'b1;
    // still below one after a capped run: resync instead of dropping by one
    if (phase_q < ONE_PHASE)
      phase_q = '0;
    else
      phase_q = phase_q - ONE_PHASE;
    hist_l[0] = hist_l[1];
    hist_l[1] = hist_l[2];
    hist_l[2] = f.left;
    hist_r[0] = hist_r[1];
    hist_r[1] = hist_r[2];
    hist_r[2] = f.right;
  endfunction

  // Mostly no gap or a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return SAMPLE_W'($urandom_range(0, 64) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    f.left  = pick_sample();
    f.right = pick_sample();
    f.upd   = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 7))
      0:       f.fill = FILL_W'($urandom);        // above capacity now and then
      1:       f.fill = '0;
      2:       f.fill = FILL_W'(FIFO_CAPACITY);
      default: f.fill = FILL_W'($urandom_range(0, FIFO_CAPACITY));
    endcase
    return f;
  endfunction

  function automatic void add_frame(input int l, input int r, input bit upd, input int fill,
                                    input bit typed, input int el, input int er);
    row_t row;
    row           = '0;
    row.kind      = ROW_FRAME;
    row.fr.left   = SAMPLE_W'(l);
    row.fr.right  = SAMPLE_W'(r);
    row.fr.upd    = upd;
    row.fr.fill   = FILL_W'(fill);
    row.typed     = typed;
    row.exp_left  = SAMPLE_W'(el);
    row.exp_right = SAMPLE_W'(er);
    plan.push_back(row);
  endfunction

  function automatic void add_regs(input int g, input int lo, input int hi);
    row_t row;
    row       = '0;
    row.kind  = ROW_REGS;
    row.gain  = GAIN_W'(g);
    row.lower = STEP_W'(lo);
    row.upper = STEP_W'(hi);
    plan.push_back(row);
  endfunction

  task automatic send_frame(input frame_t f, input bit typed,
                            input logic signed [SAMPLE_W-1:0] el,
                            input logic signed [SAMPLE_W-1:0] er);
    int unsigned gap;
    out_word_t   res [MAX_RUN];
    out_word_t   w;
    int          n;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_left_sample  <= f.left;
    in_right_sample <= f.right;
    in_update_rate  <= f.upd;
    in_fill_level   <= f.fill;
    do @(posedge clk); while (in_stall);
    resample_frame(f, res, n);
    if (typed) begin
      w.left  = el;
      w.right = er;
      w.last  = 1'b1;
      predicted_words.push_back(w);
    end else begin
      for (int i = 0; i < n; i++)
        predicted_words.push_back(res[i]);
    end
  endtask

  // Input idle, every predicted word out, then time for a frame with no output
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DRIFT_GAIN: gain_q  = val[GAIN_W-1:0];
      REG_STEP_LOWER: lower_q = val[STEP_W-1:0];
      REG_STEP_UPPER: upper_q = val[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(input logic [GAIN_W-1:0] g, input logic [STEP_W-1:0] lo,
                          input logic [STEP_W-1:0] hi);
    settle();
    write_reg(REG_DRIFT_GAIN, CFG_DW'(g));
    write_reg(REG_STEP_LOWER, CFG_DW'(lo));
    write_reg(REG_STEP_UPPER, CFG_DW'(hi));
  endtask

  // Output checker
  always @(posedge clk) begin : check_out
    out_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: L %0d R %0d last %0b",
                   out_left_out, out_right_out, out_last_of_run);
      end else begin
        w = predicted_words.pop_front();
        if (out_left_out !== w.left || out_right_out !== w.right ||
            out_last_of_run !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected L %0d R %0d last %0b, got L %0d R %0d last %0b",
                     w.left, w.right, w.last, out_left_out, out_right_out, out_last_of_run);
        end
      end
    end
  end

  // Receiver: alternating stall and open stretches, one long hold-off on request
  initial begin : rx_side
    int unsigned n;
    bit          held;
    held      = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req && !held) begin
        out_stall <= 1'b1;
        n         = HOLD_CYCLES;
        held      = 1'b1;
      end else if (out_stall) begin
        out_stall <= 1'b0;
        n         = $urandom_range(1, 40);
      end else begin
        out_stall <= 1'b1;
        n         = pick_gap() + 1;
      end
      repeat (n - 1) @(negedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** drift_steered_cubic_resampler: FAILED **");
    $finish;
  end

  initial begin : stimulus
    frame_t            f;
    logic [GAIN_W-1:0] g;
    logic [STEP_W-1:0] lo, hi;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_left_sample  = '0;
    in_right_sample = '0;
    in_update_rate  = 1'b0;
    in_fill_level   = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    hold_off_req    = 1'b0;
    reset_model();

    // Step is exactly one after reset, so each frame gives the sample two back
    add_frame( 32767, -32768, 0,     0, 1,      0,      0);
    add_frame(-32768,  32767, 0,     0, 1,      0,      0);
    add_frame(     0,      0, 0,     0, 1,  32767, -32768);
    add_frame( 32767,  32767, 0,     0, 1, -32768,  32767);
    add_frame(-32768, -32768, 0,     0, 1,      0,      0);
    add_frame(     1,     -1, 1, 16384, 1,  32767,  32767);   // zero fill error
    add_frame(  1200,  -900, 1,     0, 0, 0, 0);              // clamps to lower bound
    add_frame( -3000,  2500, 1, 32768, 0, 0, 0);              // clamps to upper bound
    add_frame( 20000, -20000, 1, 65535, 0, 0, 0);             // fill above capacity
    add_frame(-15000,  15000, 0,     0, 0, 0, 0);
    add_frame( 32767, -32768, 0,     0, 0, 0, 0);
    add_frame(-32768,  32767, 0,     0, 0, 0, 0);
    add_regs(65535, 8388608, 25165824);
    add_frame(  5000,  -5000, 1,     0, 0, 0, 0);             // step just above one half
    add_frame( 32767, -32768, 0,     0, 0, 0, 0);
    add_frame(-32768,  32767, 0,     0, 0, 0, 0);
    add_frame( 32767,  32767, 1, 65535, 0, 0, 0);             // step 1.5, frames with no word
    add_frame(-32768, -32768, 0,     0, 0, 0, 0);
    add_frame(   100,   -100, 0,     0, 0, 0, 0);
    add_regs(0, 25165824, 8388608);                           // crossed bounds
    add_frame(  7777,  -7777, 0,   300, 0, 0, 0);             // step kept, outside bounds
    add_frame( -1234,   4321, 1,   123, 0, 0, 0);
    add_regs(0, 1048576, 2097152);
    add_frame( 32767, -32768, 1, 16384, 0, 0, 0);             // step 1/8, run cap
    add_frame(-32768,  32767, 0,     0, 0, 0, 0);
    add_frame(  9999, -30000, 0,     0, 0, 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REGS)
        set_regs(plan[i].gain, plan[i].lower, plan[i].upper);
      else
        send_frame(plan[i].fr, plan[i].typed, plan[i].exp_left, plan[i].exp_right);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin g = GAIN_RESET; lo = LOWER_RESET; hi = UPPER_RESET; end
        1: begin g = 16'hFFFF; lo = STEP_W'(8388608); hi = STEP_W'(25165824); end
        2: begin g = GAIN_W'($urandom); lo = ONE_STEP; hi = ONE_STEP; end
        3: begin
          g  = GAIN_W'($urandom);
          lo = STEP_W'($urandom_range(8388608, 16777216));
          hi = STEP_W'($urandom_range(16777216, 25165824));
        end
        4: begin
          g  = GAIN_W'($urandom);
          lo = STEP_W'($urandom_range(16777216, 25165824));
          hi = STEP_W'($urandom_range(8388608, 16777216));
        end
        5: begin g = GAIN_W'($urandom); lo = '1; hi = '0; end  // crossed at the extremes: step near two or zero
        default: begin g = '0; lo = '0; hi = '1; end
      endcase
      set_regs(g, lo, hi);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        f = rand_frame();
        send_frame(f, 1'b0, '0, '0);
        if (p == 1 && k == 50)
          hold_off_req = 1'b1;
      end
    end

    settle();
    if (mismatches == 0)
      $display("** drift_steered_cubic_resampler: PASSED **");
    else
      $display("** drift_steered_cubic_resampler: FAILED **");
    $finish;
  end

endmodule
